// ===== rtl/jsnc_pkg.sv =====
package jsnc_pkg;

    typedef enum logic [3:0] {
        ST_OUT     = 4'd0,
        ST_STR     = 4'd1,
        ST_ESC     = 4'd2,
        ST_MINUS   = 4'd3,
        ST_ZERO    = 4'd4,
        ST_INT     = 4'd5,
        ST_DOT     = 4'd6,
        ST_FRAC    = 4'd7,
        ST_EXP     = 4'd8,
        ST_EXPSIGN = 4'd9,
        ST_EXPD    = 4'd10
    } t_scan_state;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_CTRL_IN  = 3'd1,
        ERR_CTRL_OUT = 3'd2,
        ERR_NUMBER   = 3'd3,
        ERR_TERM     = 3'd4,
        ERR_UNTERM   = 3'd5
    } t_err_code;

    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_E_LO   = 8'h65;
    localparam logic [7:0] CH_E_UP   = 8'h45;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

endpackage

// ===== rtl/json_strict_number_token_check.sv =====
// Strict JSON token screen. One byte request per cycle on i_data_byte/i_last while o_stall is
// low; one result per byte, in the cycle after the byte is accepted, from the result register.
// Tracks strings and escapes, rejects control bytes, and checks numbers strictly (no leading
// zeros, digits required after '-', '.', and the exponent, terminated by whitespace, ',', '}',
// ']' or end of document). The first error code is kept; the result for the last byte carries
// the verdict in o_document_valid, and the scanner then returns to its reset state for the next
// document. Throughput is one byte per cycle while o_stall is low; o_stall rises only while a
// result is held by i_stall.
module json_strict_number_token_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_error_seen,
    output logic [2:0] o_error_code,
    output logic       o_document_valid,
    output logic       o_last_out
);
    import jsnc_pkg::*;

    t_scan_state r_state, n_state;
    logic        r_err_flag, n_err_flag;
    t_err_code   r_first_err, n_first_err;

    logic        r_out_valid;
    logic        r_out_err_seen;
    t_err_code   r_out_err_code;
    logic        r_out_doc_valid;
    logic        r_out_last;

    logic        accept;
    logic        is_dig, is_ws, is_term, is_exp;
    logic        scan_raise, fin_raise;
    t_err_code   scan_code, fin_code;
    t_scan_state scan_next;
    t_scan_state out_next;
    logic        out_raise;
    logic        doc_valid;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign is_dig  = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
    assign is_ws   = (i_data_byte == CH_SPACE) || (i_data_byte == CH_TAB) ||
                     (i_data_byte == CH_CR) || (i_data_byte == CH_LF);
    assign is_term = is_ws || (i_data_byte == CH_COMMA) || (i_data_byte == CH_RBRACE) ||
                     (i_data_byte == CH_RBRACK);
    assign is_exp  = (i_data_byte == CH_E_LO) || (i_data_byte == CH_E_UP);

    // byte seen outside any token
    always_comb begin
        out_next  = ST_OUT;
        out_raise = 1'b0;
        if (i_data_byte == CH_QUOTE) begin
            out_next = ST_STR;
        end else if (i_data_byte < CTRL_LIMIT && !is_ws) begin
            out_raise = 1'b1;
        end else if (i_data_byte == CH_MINUS) begin
            out_next = ST_MINUS;
        end else if (i_data_byte == CH_ZERO) begin
            out_next = ST_ZERO;
        end else if (is_dig) begin
            out_next = ST_INT;
        end
    end

    always_comb begin
        scan_next  = r_state;
        scan_raise = 1'b0;
        scan_code  = ERR_NONE;
        case (r_state)
            ST_STR: begin
                if (i_data_byte < CTRL_LIMIT) begin
                    scan_raise = 1'b1;
                    scan_code  = ERR_CTRL_IN;
                end else if (i_data_byte == CH_BSLASH) begin
                    scan_next = ST_ESC;
                end else if (i_data_byte == CH_QUOTE) begin
                    scan_next = ST_OUT;
                end
            end
            ST_ESC: begin
                scan_next = ST_STR;
            end
            ST_MINUS: begin
                if (i_data_byte == CH_ZERO) begin
                    scan_next = ST_ZERO;
                end else if (is_dig) begin
                    scan_next = ST_INT;
                end else begin
                    scan_next  = ST_OUT;
                    scan_raise = 1'b1;
                    scan_code  = ERR_NUMBER;
                end
            end
            ST_ZERO: begin
                if (i_data_byte == CH_DOT) begin
                    scan_next = ST_DOT;
                end else if (is_exp) begin
                    scan_next = ST_EXP;
                end else if (is_dig) begin
                    scan_next  = ST_OUT;
                    scan_raise = 1'b1;
                    scan_code  = ERR_NUMBER;
                end else begin
                    scan_next  = ST_OUT;
                    scan_raise = !is_term;
                    scan_code  = ERR_TERM;
                end
            end
            ST_INT: begin
                if (is_dig) begin
                    scan_next = ST_INT;
                end else if (i_data_byte == CH_DOT) begin
                    scan_next = ST_DOT;
                end else if (is_exp) begin
                    scan_next = ST_EXP;
                end else begin
                    scan_next  = ST_OUT;
                    scan_raise = !is_term;
                    scan_code  = ERR_TERM;
                end
            end
            ST_DOT: begin
                if (is_dig) begin
                    scan_next = ST_FRAC;
                end else begin
                    scan_next  = ST_OUT;
                    scan_raise = 1'b1;
                    scan_code  = ERR_NUMBER;
                end
            end
            ST_FRAC: begin
                if (is_dig) begin
                    scan_next = ST_FRAC;
                end else if (is_exp) begin
                    scan_next = ST_EXP;
                end else begin
                    scan_next  = ST_OUT;
                    scan_raise = !is_term;
                    scan_code  = ERR_TERM;
                end
            end
            ST_EXP: begin
                if (i_data_byte == CH_PLUS || i_data_byte == CH_MINUS) begin
                    scan_next = ST_EXPSIGN;
                end else if (is_dig) begin
                    scan_next = ST_EXPD;
                end else begin
                    scan_next  = ST_OUT;
                    scan_raise = 1'b1;
                    scan_code  = ERR_NUMBER;
                end
            end
            ST_EXPSIGN: begin
                if (is_dig) begin
                    scan_next = ST_EXPD;
                end else begin
                    scan_next  = ST_OUT;
                    scan_raise = 1'b1;
                    scan_code  = ERR_NUMBER;
                end
            end
            ST_EXPD: begin
                if (!is_dig) begin
                    scan_next  = ST_OUT;
                    scan_raise = !is_term;
                    scan_code  = ERR_TERM;
                end
            end
            default: begin
                scan_next  = out_next;
                scan_raise = out_raise;
                scan_code  = ERR_CTRL_OUT;
            end
        endcase
    end

    // end-of-document checks
    always_comb begin
        fin_raise = 1'b0;
        fin_code  = ERR_NONE;
        if (i_last) begin
            if (scan_next == ST_STR || scan_next == ST_ESC) begin
                fin_raise = 1'b1;
                fin_code  = ERR_UNTERM;
            end else if (scan_next == ST_MINUS || scan_next == ST_DOT ||
                         scan_next == ST_EXP || scan_next == ST_EXPSIGN) begin
                fin_raise = 1'b1;
                fin_code  = ERR_NUMBER;
            end
        end
    end

    always_comb begin
        n_err_flag  = r_err_flag || scan_raise || fin_raise;
        n_first_err = r_first_err;
        if (!r_err_flag) begin
            if (scan_raise) begin
                n_first_err = scan_code;
            end else if (fin_raise) begin
                n_first_err = fin_code;
            end
        end
        n_state   = scan_next;
        doc_valid = i_last && !n_err_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_OUT;
            r_err_flag  <= 1'b0;
            r_first_err <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (i_last) begin
                    r_state     <= ST_OUT;
                    r_err_flag  <= 1'b0;
                    r_first_err <= ERR_NONE;
                end else begin
                    r_state     <= n_state;
                    r_err_flag  <= n_err_flag;
                    r_first_err <= n_first_err;
                end
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_err_seen  <= n_err_flag;
            r_out_err_code  <= n_first_err;
            r_out_doc_valid <= doc_valid;
            r_out_last      <= i_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_error_seen     = r_out_err_seen;
    assign o_error_code     = r_out_err_code;
    assign o_document_valid = r_out_doc_valid;
    assign o_last_out       = r_out_last;

    a_verdict_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_document_valid |-> o_last_out && !o_error_seen)
        else $error("verdict valid off last byte or with error");

    a_code_matches_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err_flag == (r_first_err != ERR_NONE))
        else $error("error flag and first error code disagree");

    a_reset_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last |=> r_state == ST_OUT && !r_err_flag)
        else $error("scanner not cleared after last byte");

    a_first_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_last && r_err_flag |=> r_err_flag && r_first_err == $past(r_first_err))
        else $error("first error code overwritten");

endmodule
